### design/mts_pkg.sv
// mts_pkg: shared types and constants for the marquee text scroller
// no dependencies; used by every module of the block
`default_nettype none

package mts_pkg;

	localparam int STORE_DEPTH     = 64;
	localparam int SCREEN_WIDTH    = 16;
	localparam int DIGITS_PER_CHIP = 4;

	localparam int ADDR_W = $clog2(STORE_DEPTH);
	localparam int OFS_W  = $clog2(STORE_DEPTH + 1);
	localparam int SRC_W  = OFS_W + 1;
	localparam int POS_W  = $clog2(SCREEN_WIDTH);
	localparam int DIG_W  = 2;
	localparam int CHIP_W = 2;
	localparam int CHAR_W = 8;

	typedef enum logic [1:0] {
		CMD_TICK    = 2'd0,
		CMD_LOAD    = 2'd1,
		CMD_RESTART = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_code_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_FIRST,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [ADDR_W-1:0] byte_index;
		logic [CHAR_W-1:0] byte_value;
		logic [POS_W-1:0]  start_position;
	} req_t;

	typedef struct packed {
		logic [CHIP_W-1:0] chip;
		logic [DIG_W-1:0]  digit;
		logic [CHAR_W-1:0] character;
		logic              clear_chip;
		logic              last;
	} wr_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic restart;
		logic start_early;
		logic start_check;
		logic wrap;
		logic advance;
		logic fetch;
		logic emit;
		logic step;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic pos_gt_half;
		logic rd_zero;
		logic emit_last;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

### design/marquee_text_scroller.sv
// marquee_text_scroller: top level, mts_ctrl sequencer plus mts_dpath; depends on mts_pkg
// load and restart requests complete on acceptance; a tick's first digit write is registered
// in ST_EMIT, reached through ST_FIRST (sliding in) or ST_CHECK and ST_FIRST (scrolling), then
// one write a cycle while wr_ready does not stall the output, paced by the single read port of
// the message store; a full screen of 16 writes keeps req_ready low until the last is registered
// reset (arst_n, asynchronous): store reads as zeros, screen position 8, text offset 0
`default_nettype none

module marquee_text_scroller (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire mts_pkg::req_t req,
	output logic               wr_valid,
	input  wire logic          wr_ready,
	output mts_pkg::wr_t       wr
);

	mts_pkg::ctl_t ctl;
	mts_pkg::sts_t sts;

	mts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.cmd       (req.cmd),
		.sts       (sts),
		.ctl       (ctl)
	);

	mts_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.ctl      (ctl),
		.sts      (sts),
		.wr_valid (wr_valid),
		.wr_ready (wr_ready),
		.wr       (wr)
	);

endmodule

`default_nettype wire

### design/mts_ctrl.sv
// mts_ctrl: sequencer for one request at a time (tick, load, restart)
// depends on mts_pkg
`default_nettype none

module mts_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire logic [1:0]    cmd,
	input  wire mts_pkg::sts_t sts,
	output mts_pkg::ctl_t      ctl
);

	mts_pkg::state_t state_q;
	mts_pkg::state_t state_d;
	logic            accept;
	logic            is_tick;

	assign req_ready = (state_q == mts_pkg::ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign is_tick   = (cmd == mts_pkg::CMD_TICK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mts_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mts_pkg::ST_IDLE: begin
				if (accept && is_tick) begin
					state_d = sts.pos_gt_half ? mts_pkg::ST_FIRST : mts_pkg::ST_CHECK;
				end
			end
			mts_pkg::ST_CHECK: begin
				state_d = sts.rd_zero ? mts_pkg::ST_IDLE : mts_pkg::ST_FIRST;
			end
			mts_pkg::ST_FIRST: begin
				state_d = sts.rd_zero ? mts_pkg::ST_IDLE : mts_pkg::ST_EMIT;
			end
			mts_pkg::ST_EMIT: begin
				if (sts.out_free && sts.emit_last) begin
					state_d = mts_pkg::ST_IDLE;
				end
			end
			default: state_d = mts_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		unique case (state_q)
			mts_pkg::ST_IDLE: begin
				ctl.load        = accept && (cmd == mts_pkg::CMD_LOAD);
				ctl.restart     = accept && (cmd == mts_pkg::CMD_RESTART);
				ctl.start_early = accept && is_tick && sts.pos_gt_half;
				ctl.start_check = accept && is_tick && !sts.pos_gt_half;
			end
			mts_pkg::ST_CHECK: begin
				ctl.wrap    = sts.rd_zero;
				ctl.advance = !sts.rd_zero;
			end
			mts_pkg::ST_FIRST: begin
				ctl.fetch = !sts.rd_zero;
			end
			mts_pkg::ST_EMIT: begin
				ctl.emit = sts.out_free;
				ctl.step = sts.out_free && !sts.emit_last;
			end
			default: ctl = '0;
		endcase
	end

endmodule

`default_nettype wire

### design/mts_dpath.sv
// mts_dpath: message store, scroll position registers, walk pointers, write register
// depends on mts_pkg; driven by mts_ctrl
`default_nettype none

module mts_dpath (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire mts_pkg::req_t req,
	input  wire mts_pkg::ctl_t ctl,
	output mts_pkg::sts_t      sts,
	output logic               wr_valid,
	input  wire logic          wr_ready,
	output mts_pkg::wr_t       wr
);

	logic [mts_pkg::CHAR_W-1:0]      mem [mts_pkg::STORE_DEPTH];
	logic [mts_pkg::STORE_DEPTH-1:0] vld_q;

	logic [mts_pkg::POS_W-1:0]  pos_q;
	logic [mts_pkg::OFS_W-1:0]  offset_q;
	logic [mts_pkg::POS_W-1:0]  walk_pos_q;
	logic [mts_pkg::SRC_W-1:0]  src_q;
	logic [mts_pkg::CHAR_W-1:0] cur_q;
	logic [mts_pkg::CHAR_W-1:0] rd_data_q;
	logic                       rd_ok_q;
	logic                       wr_valid_q;
	mts_pkg::wr_t               wr_q;

	logic                       rd_en;
	logic [mts_pkg::SRC_W-1:0]  rd_addr;
	logic [mts_pkg::ADDR_W-1:0] rd_idx;
	logic                       rd_in_range;
	logic [mts_pkg::CHAR_W-1:0] rd_char;
	logic                       out_free;
	logic                       emit_last;

	assign rd_en = ctl.start_early | ctl.start_check | ctl.advance | ctl.fetch | ctl.step;

	always_comb begin
		if (ctl.start_early) begin
			rd_addr = '0;
		end else if (ctl.start_check) begin
			rd_addr = mts_pkg::SRC_W'(offset_q);
		end else if (ctl.advance) begin
			rd_addr = mts_pkg::SRC_W'(offset_q) + mts_pkg::SRC_W'(1);
		end else begin
			rd_addr = src_q;
		end
	end

	assign rd_idx      = rd_addr[mts_pkg::ADDR_W-1:0];
	assign rd_in_range = (rd_addr < mts_pkg::SRC_W'(mts_pkg::STORE_DEPTH));
	// past the end of the store, or never loaded, reads as a terminator
	assign rd_char     = rd_ok_q ? rd_data_q : '0;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			mem[req.byte_index] <= req.byte_value;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			rd_ok_q <= 1'b0;
		end else begin
			if (ctl.load) begin
				vld_q[req.byte_index] <= 1'b1;
			end
			if (rd_en) begin
				rd_ok_q <= rd_in_range && vld_q[rd_idx];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= mts_pkg::POS_W'(mts_pkg::SCREEN_WIDTH / 2);
			offset_q <= '0;
		end else begin
			if (ctl.restart) begin
				pos_q    <= req.start_position;
				offset_q <= '0;
			end else if (ctl.wrap) begin
				pos_q    <= mts_pkg::POS_W'(mts_pkg::SCREEN_WIDTH - 1);
				offset_q <= '0;
			end else if (ctl.start_early) begin
				pos_q <= pos_q - mts_pkg::POS_W'(1);
			end else if (ctl.advance) begin
				offset_q <= offset_q + mts_pkg::OFS_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start_early) begin
			walk_pos_q <= pos_q;
			src_q      <= mts_pkg::SRC_W'(1);
		end else if (ctl.advance) begin
			walk_pos_q <= pos_q;
			src_q      <= mts_pkg::SRC_W'(offset_q) + mts_pkg::SRC_W'(2);
		end else if (ctl.fetch || ctl.step) begin
			src_q <= src_q + mts_pkg::SRC_W'(1);
		end
		if (ctl.step) begin
			walk_pos_q <= walk_pos_q + mts_pkg::POS_W'(1);
		end
		if (ctl.fetch || ctl.step) begin
			cur_q <= rd_char;
		end
	end

	// rd_char here is the character after cur_q
	assign emit_last = (walk_pos_q == mts_pkg::POS_W'(mts_pkg::SCREEN_WIDTH - 1))
		|| (rd_char == '0);
	assign out_free  = !wr_valid_q || wr_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			wr_valid_q <= 1'b1;
		end else if (wr_ready) begin
			wr_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			wr_q.chip       <= mts_pkg::CHIP_W'(walk_pos_q / mts_pkg::DIGITS_PER_CHIP);
			wr_q.digit      <= mts_pkg::DIG_W'(mts_pkg::DIGITS_PER_CHIP - 1)
				- mts_pkg::DIG_W'(walk_pos_q % mts_pkg::DIGITS_PER_CHIP);
			wr_q.character  <= cur_q;
			wr_q.clear_chip <= (walk_pos_q % mts_pkg::DIGITS_PER_CHIP) == 0;
			wr_q.last       <= emit_last;
		end
	end

	assign sts.pos_gt_half = pos_q > mts_pkg::POS_W'(mts_pkg::SCREEN_WIDTH / 2);
	assign sts.rd_zero     = (rd_char == '0);
	assign sts.emit_last   = emit_last;
	assign sts.out_free    = out_free;

	assign wr_valid = wr_valid_q;
	assign wr       = wr_q;

endmodule

`default_nettype wire

### design/mts_checker.sv
// mts_checker: port-level checks on the marquee text scroller
// depends on mts_pkg; bound to marquee_text_scroller below
`default_nettype none

module mts_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_valid,
	input wire logic          req_ready,
	input wire mts_pkg::req_t req,
	input wire logic          wr_valid,
	input wire logic          wr_ready,
	input wire mts_pkg::wr_t  wr
);

	// a pending digit write holds until taken
	a_wr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		wr_valid && !wr_ready |=> wr_valid && $stable(wr))
		else $error("digit write dropped or changed while stalled");

	// loads, restarts and unused commands never start a write
	a_no_wr_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req.cmd != mts_pkg::CMD_TICK) |=> !$rose(wr_valid))
		else $error("write appeared after a non-tick request");

	// a tick is still busy while a non-final write is taken
	a_busy_mid_tick: assert property (@(posedge clk) disable iff (!arst_n)
		wr_valid && wr_ready && !wr.last |-> !req_ready)
		else $error("request taken in the middle of a tick");

	// the first digit of a chip carries the clear
	a_clear_digit: assert property (@(posedge clk) disable iff (!arst_n)
		wr_valid && wr.clear_chip |-> wr.digit == mts_pkg::DIG_W'(mts_pkg::DIGITS_PER_CHIP - 1))
		else $error("chip clear on the wrong digit");

endmodule

bind marquee_text_scroller mts_checker u_mts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.wr_valid  (wr_valid),
	.wr_ready  (wr_ready),
	.wr        (wr)
);

`default_nettype wire

### verif/tb_marquee_text_scroller.sv
// tb_marquee_text_scroller: self-checking bench for the marquee text scroller
// predicts each digit write in the bench and checks every write in order;
// depends on mts_pkg and marquee_text_scroller
`timescale 1ns / 100ps

module tb_marquee_text_scroller;

	logic          clk;
	logic          arst_n;
	logic          req_valid;
	logic          req_ready;
	mts_pkg::req_t req;
	logic          wr_valid;
	logic          wr_ready;
	mts_pkg::wr_t  wr;

	// bench copy of the scroller state
	logic [mts_pkg::CHAR_W-1:0] msg_bytes [mts_pkg::STORE_DEPTH];
	int                         scr_pos;
	int                         txt_ofs;

	mts_pkg::wr_t digit_writes [$];
	int           mismatch_count;
	int           sent_items;
	bit           no_idle;

	marquee_text_scroller uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.wr_valid  (wr_valid),
		.wr_ready  (wr_ready),
		.wr        (wr)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// past the end of the store reads as a terminator
	function automatic int read_byte(input int addr);
		if (addr >= mts_pkg::STORE_DEPTH)
			return 0;
		return msg_bytes[addr];
	endfunction

	// one write per screen position from start_pos, up to the first zero byte or the screen's right edge
	task automatic queue_text(input int start_pos, input int src);
		int           pos;
		int           addr;
		bit           held;
		mts_pkg::wr_t w;
		pos  = start_pos;
		addr = src;
		held = 1'b0;
		w    = '0;
		while (pos < mts_pkg::SCREEN_WIDTH && read_byte(addr) != 0) begin
			if (held)
				digit_writes.push_back(w);
			w.chip       = mts_pkg::CHIP_W'(pos / mts_pkg::DIGITS_PER_CHIP);
			w.digit      = mts_pkg::DIG_W'(mts_pkg::DIGITS_PER_CHIP - 1
				- pos % mts_pkg::DIGITS_PER_CHIP);
			w.character  = mts_pkg::CHAR_W'(read_byte(addr));
			w.clear_chip = (pos % mts_pkg::DIGITS_PER_CHIP == 0);
			w.last       = 1'b0;
			held = 1'b1;
			pos++;
			addr++;
		end
		if (held) begin
			w.last = 1'b1;
			digit_writes.push_back(w);
		end
	endtask

	task automatic predict_req(input mts_pkg::req_t r);
		case (r.cmd)
			mts_pkg::CMD_LOAD: begin
				msg_bytes[r.byte_index] = r.byte_value;
			end
			mts_pkg::CMD_RESTART: begin
				txt_ofs = 0;
				scr_pos = r.start_position;
			end
			mts_pkg::CMD_TICK: begin
				if (scr_pos > mts_pkg::SCREEN_WIDTH / 2) begin
					// sliding in from the right
					queue_text(scr_pos, 0);
					scr_pos--;
				end else if (read_byte(txt_ofs) != 0) begin
					txt_ofs++;
					queue_text(scr_pos, txt_ofs);
				end else begin
					scr_pos = mts_pkg::SCREEN_WIDTH - 1;
					txt_ofs = 0;
				end
			end
			default: ;
		endcase
	endtask

	function automatic mts_pkg::req_t make_req(input mts_pkg::cmd_code_t c,
			input int idx = 0, input int val = 0, input int pos = 0);
		mts_pkg::req_t r;
		r.cmd            = c;
		r.byte_index     = mts_pkg::ADDR_W'(idx);
		r.byte_value     = mts_pkg::CHAR_W'(val);
		r.start_position = mts_pkg::POS_W'(pos);
		return r;
	endfunction

	// called and returns at a falling edge; valid is left high for the next request
	task automatic send_req(input mts_pkg::req_t r);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			req_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req       = r;
		req_valid = 1'b1;
		do @(posedge clk); while (!req_ready);
		predict_req(r);
		sent_items++;
		@(negedge clk);
	endtask

	task automatic wait_writes_done();
		req_valid = 1'b0;
		while (digit_writes.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// write sink: stall drawn before every write
	initial begin
		int gap;
		wr_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			gap = no_idle ? 0 : $urandom_range(0, 6);
			wr_ready = 1'b0;
			repeat (gap) @(negedge clk);
			wr_ready = 1'b1;
			do @(posedge clk); while (!wr_valid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && wr_valid && wr_ready) begin
			if (digit_writes.size() == 0) begin
				$display("%0t: expected no write, got %p", $time, wr);
				mismatch_count++;
			end else begin
				mts_pkg::wr_t want;
				want = digit_writes.pop_front();
				check_field("chip", want.chip, wr.chip);
				check_field("digit", want.digit, wr.digit);
				check_field("character", want.character, wr.character);
				check_field("clear_chip", want.clear_chip, wr.clear_chip);
				check_field("last", want.last, wr.last);
			end
		end
	end

	// empty store: the first tick wraps, later ones slide in nothing
	task automatic test_empty_store();
		repeat (3)
			send_req(make_req(mts_pkg::CMD_TICK));
		wait_writes_done();
	endtask

	task automatic test_unused_cmd();
		send_req(make_req(mts_pkg::CMD_NONE, 63, 255, 15));
		send_req(make_req(mts_pkg::CMD_NONE, 21, 170, 5));
		send_req(make_req(mts_pkg::CMD_TICK));
		wait_writes_done();
	endtask

	// short text slides in, scrolls off and wraps back to the right edge
	task automatic test_slide_and_scroll();
		send_req(make_req(mts_pkg::CMD_LOAD, 0, 8'h01));
		send_req(make_req(mts_pkg::CMD_LOAD, 1, 8'hFF));
		send_req(make_req(mts_pkg::CMD_LOAD, 2, 8'h80));
		send_req(make_req(mts_pkg::CMD_RESTART, 0, 0, 9));
		repeat (6)
			send_req(make_req(mts_pkg::CMD_TICK));
		wait_writes_done();
	endtask

	// left edge, chip boundary and text cut off by the right edge
	task automatic test_screen_edges();
		send_req(make_req(mts_pkg::CMD_RESTART, 0, 0, 0));
		send_req(make_req(mts_pkg::CMD_TICK));
		send_req(make_req(mts_pkg::CMD_RESTART, 0, 0, 12));
		send_req(make_req(mts_pkg::CMD_TICK));
		send_req(make_req(mts_pkg::CMD_RESTART, 0, 0, 14));
		send_req(make_req(mts_pkg::CMD_TICK));
		send_req(make_req(mts_pkg::CMD_RESTART, 0, 0, 15));
		send_req(make_req(mts_pkg::CMD_TICK));
		wait_writes_done();
	endtask

	// full store with no terminator: full-screen writes until the store end stops the text
	task automatic test_store_end();
		no_idle = 1'b0;
		for (int i = 0; i < mts_pkg::STORE_DEPTH; i++)
			send_req(make_req(mts_pkg::CMD_LOAD, i, $urandom_range(1, 255)));
		send_req(make_req(mts_pkg::CMD_RESTART, 0, 0, 0));
		repeat (mts_pkg::STORE_DEPTH + 2)
			send_req(make_req(mts_pkg::CMD_TICK));
		wait_writes_done();
	endtask

	// mostly well-formed messages with random content, plus stray requests
	task automatic test_random_mix();
		int kind;
		int len;
		while (sent_items < 180) begin
			no_idle = ($urandom_range(0, 4) == 0);
			kind = $urandom_range(0, 9);
			if (kind < 6) begin
				len = ($urandom_range(0, 5) == 0) ? $urandom_range(21, 40)
					: $urandom_range(1, 20);
				for (int i = 0; i < len; i++)
					send_req(make_req(mts_pkg::CMD_LOAD, i, $urandom_range(1, 255)));
				if ($urandom_range(0, 7) != 0)
					send_req(make_req(mts_pkg::CMD_LOAD, len, 0));
				send_req(make_req(mts_pkg::CMD_RESTART, $urandom, $urandom,
					$urandom_range(0, 15)));
				repeat ($urandom_range(1, 24))
					send_req(make_req(mts_pkg::CMD_TICK, $urandom, $urandom, $urandom));
			end else begin
				repeat ($urandom_range(1, 6))
					send_req(make_req(mts_pkg::cmd_code_t'($urandom_range(0, 3)),
						$urandom, $urandom, $urandom));
			end
			if ($urandom_range(0, 3) == 0)
				wait_writes_done();
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		no_idle   = 1'b0;
		mismatch_count = 0;
		sent_items     = 0;
		scr_pos = mts_pkg::SCREEN_WIDTH / 2;
		txt_ofs = 0;
		for (int i = 0; i < mts_pkg::STORE_DEPTH; i++)
			msg_bytes[i] = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_empty_store();
		test_unused_cmd();
		test_slide_and_scroll();
		no_idle = 1'b1;
		test_screen_edges();
		no_idle = 1'b0;
		test_store_end();
		test_random_mix();

		wait_writes_done();
		repeat (30) @(negedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### files.f
design/mts_pkg.sv
design/mts_ctrl.sv
design/mts_dpath.sv
design/marquee_text_scroller.sv
design/mts_checker.sv
verif/tb_marquee_text_scroller.sv
